### src/cie_pkg.sv
// shared types and constants for the custom isa execute unit
`timescale 1ns / 1ps
package cie_pkg;

	localparam logic [4:0] ZF_IDX = 5'd27;
	localparam logic [4:0] SF_IDX = 5'd28;

	localparam logic [2:0] GRP_LABEL = 3'b000;
	localparam logic [2:0] GRP_IMM   = 3'b001;
	localparam logic [2:0] GRP_JUMP  = 3'b010;
	localparam logic [2:0] GRP_RR    = 3'b011;
	localparam logic [2:0] GRP_UNARY = 3'b100;
	localparam logic [2:0] GRP_SYS   = 3'b101;

	localparam logic [10:0] OP_MVI  = 11'h100;
	localparam logic [10:0] OP_SUBI = 11'h101;
	localparam logic [10:0] OP_ADDI = 11'h102;
	localparam logic [10:0] OP_MULI = 11'h103;
	localparam logic [10:0] OP_DIVI = 11'h104;
	localparam logic [10:0] OP_MODI = 11'h105;
	localparam logic [10:0] OP_CMPI = 11'h106;

	localparam logic [15:0] OP_JZR = 16'h40E0;
	localparam logic [15:0] OP_JEQ = 16'h40E1;
	localparam logic [15:0] OP_JMP = 16'h40E2;
	localparam logic [15:0] OP_JLE = 16'h40E3;

	localparam logic [21:0] OP_RR_BASE = 22'h183900;

	localparam logic [26:0] OP_INC = 27'h4072121;
	localparam logic [26:0] OP_DEC = 27'h4072122;
	localparam logic [26:0] OP_INP = 27'h4072123;
	localparam logic [26:0] OP_OUT = 27'h4072124;

	localparam logic [31:0] OP_HLT = 32'hA0E42480;

	// alu operation codes
	localparam logic [3:0] ALU_NONE = 4'd0;
	localparam logic [3:0] ALU_MOV  = 4'd1;
	localparam logic [3:0] ALU_SUB  = 4'd2;
	localparam logic [3:0] ALU_ADD  = 4'd3;
	localparam logic [3:0] ALU_MUL  = 4'd4;
	localparam logic [3:0] ALU_DIV  = 4'd5;
	localparam logic [3:0] ALU_MOD  = 4'd6;
	localparam logic [3:0] ALU_CMP  = 4'd7;
	localparam logic [3:0] ALU_AND  = 4'd8;
	localparam logic [3:0] ALU_OR   = 4'd9;
	localparam logic [3:0] ALU_JCND = 4'd10;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic exec;
		logic div_start;
		logic div_step;
		logic div_finish;
		logic result;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic needs_div;
		logic div_last;
	} status_t;

endpackage

### src/cie_datapath.sv
// datapath: register file, decode, alu, multi-cycle divider, result register
`timescale 1ns / 1ps
module cie_datapath #(
	parameter int NUM_REGS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  cie_pkg::cmd_t    cmd,
	output cie_pkg::status_t status,
	input  logic [31:0]    instr_word,
	input  logic signed [31:0] in_value,
	output logic           out_valid,
	output logic signed [63:0] out_value,
	output logic           jump_taken,
	output logic [15:0]    jump_label,
	output logic           is_label,
	output logic           halt,
	output logic           div_error
);
	import cie_pkg::*;

	logic [63:0] regs_q [NUM_REGS];
	logic [31:0] iw_q;
	logic [63:0] inv_q;

	// latch the transaction
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			iw_q  <= instr_word;
			inv_q <= {{32{in_value[31]}}, in_value};
		end
	end

	function automatic logic [63:0] rdreg(input logic [4:0] i, input logic [63:0] r [NUM_REGS]);
		logic [63:0] v;
		v = '0;
		for (int k = 0; k < NUM_REGS; k++)
			if (i == 5'(k)) v = r[k];
		return v;
	endfunction

	// decode
	logic [3:0]  aop;
	logic [4:0]  dst;
	logic [63:0] opb;
	logic        o_out, o_jmp, o_lbl, o_hlt;
	logic [63:0] a_val;
	logic [4:0]  rrsub;

	always_comb begin
		aop = ALU_NONE;
		dst = iw_q[20:16];
		opb = {48'd0, iw_q[15:0]};
		o_out = 1'b0; o_jmp = 1'b0; o_lbl = 1'b0; o_hlt = 1'b0;
		rrsub = 5'(iw_q[31:10] - OP_RR_BASE);
		case (iw_q[31:29])
			GRP_IMM: begin
				case (iw_q[31:21])
					OP_MVI:  aop = ALU_MOV;
					OP_SUBI: aop = ALU_SUB;
					OP_ADDI: aop = ALU_ADD;
					OP_MULI: aop = ALU_MUL;
					OP_DIVI: aop = ALU_DIV;
					OP_MODI: aop = ALU_MOD;
					OP_CMPI: aop = ALU_CMP;
					default: aop = ALU_NONE;
				endcase
			end
			GRP_JUMP: begin
				case (iw_q[31:16])
					OP_JMP:                 o_jmp = 1'b1;
					OP_JZR, OP_JEQ, OP_JLE: aop = ALU_JCND;
					default:                aop = ALU_NONE;
				endcase
			end
			GRP_RR: begin
				dst = iw_q[9:5];
				opb = rdreg(iw_q[4:0], regs_q);
				if (iw_q[31:10] >= OP_RR_BASE && iw_q[31:10] <= OP_RR_BASE + 22'd8) begin
					case (rrsub)
						5'd0: aop = ALU_MOV;
						5'd1: aop = ALU_SUB;
						5'd2: aop = ALU_ADD;
						5'd3: aop = ALU_MUL;
						5'd4: aop = ALU_DIV;
						5'd5: aop = ALU_MOD;
						5'd6: aop = ALU_CMP;
						5'd7: aop = ALU_AND;
						default: aop = ALU_OR;
					endcase
				end
			end
			GRP_UNARY: begin
				dst = iw_q[4:0];
				case (iw_q[31:5])
					OP_INC: begin aop = ALU_ADD; opb = 64'd1; end
					OP_DEC: begin aop = ALU_SUB; opb = 64'd1; end
					OP_INP: begin aop = ALU_MOV; opb = inv_q; end
					OP_OUT: o_out = 1'b1;
					default: aop = ALU_NONE;
				endcase
			end
			GRP_SYS:   o_hlt = (iw_q == OP_HLT);
			GRP_LABEL: o_lbl = 1'b1;
			default:   aop = ALU_NONE;
		endcase
		a_val = rdreg(dst, regs_q);
	end

	assign status.needs_div = (aop == ALU_DIV || aop == ALU_MOD) && (opb != 64'd0);

	// multiply: 32x32 partial products over the exec cycle, summed on write
	logic [63:0] pp_ll, pp_lh, pp_hl;
	always_comb begin
		pp_ll = a_val[31:0] * opb[31:0];
		pp_lh = 64'(a_val[31:0] * opb[63:32]);
		pp_hl = 64'(a_val[63:32] * opb[31:0]);
	end

	// divider: restoring, one bit a cycle on magnitudes
	logic [63:0] dq_q, dr_q, dd_q;
	logic        dna_q, dnb_q, dmod_q;
	logic [5:0]  dcnt_q;
	logic [4:0]  ddst_q;
	logic [64:0] trial;
	assign trial = {dr_q, dq_q[63]} - {1'b0, dd_q};
	assign status.div_last = (dcnt_q == 6'd63);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dcnt_q <= '0;
		else if (cmd.div_start) dcnt_q <= '0;
		else if (cmd.div_step) dcnt_q <= dcnt_q + 6'd1;
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dna_q  <= a_val[63];
			dnb_q  <= opb[63];
			dmod_q <= (aop == ALU_MOD);
			ddst_q <= dst;
			dq_q   <= a_val[63] ? -a_val : a_val;
			dd_q   <= opb[63] ? -opb : opb;
			dr_q   <= '0;
		end else if (cmd.div_step) begin
			if (!trial[64]) begin
				dr_q <= trial[63:0];
				dq_q <= {dq_q[62:0], 1'b1};
			end else begin
				dr_q <= {dr_q[62:0], dq_q[63]};
				dq_q <= {dq_q[62:0], 1'b0};
			end
		end
	end

	// multiply sum stage
	logic [63:0] mul_lo_s1, mul_cross_s1;
	logic [4:0]  mdst_s1;
	logic        mul_pend_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mul_pend_q <= 1'b0;
		else mul_pend_q <= cmd.exec && (aop == ALU_MUL);
	end
	always_ff @(posedge clk) begin
		mul_lo_s1    <= pp_ll;
		mul_cross_s1 <= pp_lh + pp_hl;
		mdst_s1      <= dst;
	end

	// write-back value
	logic        we;
	logic [4:0]  wa;
	logic [63:0] wd;
	logic        flag_we;
	logic        zf_n, sf_n;
	logic [63:0] q_s, r_s;
	always_comb begin
		we = 1'b0; wa = dst; wd = '0;
		flag_we = 1'b0; zf_n = 1'b0; sf_n = 1'b0;
		q_s = (dna_q != dnb_q) ? -dq_q : dq_q;
		r_s = dna_q ? -dr_q : dr_q;
		if (mul_pend_q) begin
			we = 1'b1; wa = mdst_s1;
			wd = mul_lo_s1 + {mul_cross_s1[31:0], 32'd0};
		end else if (cmd.div_finish) begin
			we = 1'b1; wa = ddst_q;
			wd = dmod_q ? r_s : q_s;
		end else if (cmd.exec) begin
			case (aop)
				ALU_MOV: begin we = 1'b1; wd = opb; end
				ALU_SUB: begin we = 1'b1; wd = a_val - opb; end
				ALU_ADD: begin we = 1'b1; wd = a_val + opb; end
				ALU_AND: begin we = 1'b1; wd = a_val & opb; end
				ALU_OR:  begin we = 1'b1; wd = a_val | opb; end
				ALU_CMP: begin
					flag_we = 1'b1;
					zf_n = (a_val == opb);
					sf_n = !zf_n && ($signed(a_val) < $signed(opb));
				end
				ALU_JCND: flag_we = 1'b1;
				default: we = 1'b0;
			endcase
		end
	end

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_REGS; k++) regs_q[k] <= '0;
		end else begin
			for (int k = 0; k < NUM_REGS; k++) begin
				if (we && wa == 5'(k)) regs_q[k] <= wd;
				if (flag_we && ZF_IDX == 5'(k)) regs_q[k] <= {63'd0, zf_n};
				if (flag_we && SF_IDX == 5'(k)) regs_q[k] <= {63'd0, sf_n};
			end
		end
	end

	// jump condition uses flags before the clear
	logic take;
	always_comb begin
		take = o_jmp;
		if (aop == ALU_JCND) begin
			if (iw_q[31:16] == OP_JLE) take = (rdreg(SF_IDX, regs_q) == 64'd1);
			else take = (rdreg(ZF_IDX, regs_q) == 64'd1);
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			out_valid  <= o_out;
			out_value  <= o_out ? a_val : 64'd0;
			jump_taken <= take;
			jump_label <= take ? iw_q[15:0] : 16'd0;
			is_label   <= o_lbl;
			halt       <= o_hlt;
			div_error  <= (aop == ALU_DIV || aop == ALU_MOD) && (opb == 64'd0);
		end
	end
endmodule

### src/cie_ctrl.sv
// controller: sequences load, execute, divide iterations and result delivery
`timescale 1ns / 1ps
module cie_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid_hs,
	input  logic           out_stall,
	output cie_pkg::cmd_t    cmd,
	input  cie_pkg::status_t status
);
	import cie_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_DFIN = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0] state_q;

	assign in_stall     = (state_q != S_IDLE);
	assign out_valid_hs = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		cmd.load       = (state_q == S_IDLE) && in_valid;
		cmd.exec       = (state_q == S_EXEC);
		cmd.div_start  = (state_q == S_EXEC) && status.needs_div;
		cmd.div_step   = (state_q == S_DIV);
		cmd.div_finish = (state_q == S_DFIN);
	end

	// state sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_EXEC;
				S_EXEC: state_q <= status.needs_div ? S_DIV : S_OUT;
				S_DIV:  if (status.div_last) state_q <= S_DFIN;
				S_DFIN: state_q <= S_OUT;
				S_OUT:  if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### src/custom_isa_execute_unit_top.sv
// custom isa execute unit: one instruction per transaction, one result each
// states: idle, execute, deliver; a nonzero divide or modulo adds divide and finish states before deliver
// one transaction at a time: in_stall stays high from acceptance until the result is taken
// divide and modulo by a nonzero operand iterate one quotient bit a cycle
// reset: arst_n clears the controller and zeroes every register of the file
`timescale 1ns / 1ps
module custom_isa_execute_unit_top #(
	parameter int NUM_REGS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        instr_word,
	input  logic signed [31:0] in_value,
	output logic               res_valid,
	input  logic               res_stall,
	output logic               out_valid,
	output logic signed [63:0] out_value,
	output logic               jump_taken,
	output logic [15:0]        jump_label,
	output logic               is_label,
	output logic               halt,
	output logic               div_error
);
	import cie_pkg::*;

	cmd_t    cmd;
	status_t status;

	// controller
	cie_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_valid_hs(res_valid), .out_stall(res_stall),
		.cmd(cmd), .status(status)
	);

	// datapath
	cie_datapath #(.NUM_REGS(NUM_REGS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.instr_word(instr_word), .in_value(in_value),
		.out_valid(out_valid), .out_value(out_value),
		.jump_taken(jump_taken), .jump_label(jump_label),
		.is_label(is_label), .halt(halt), .div_error(div_error)
	);
endmodule
